FILE: hdl/keyed_slot_buffer_unit_macros.svh
`ifndef KEYED_SLOT_BUFFER_UNIT_MACROS_SVH
`define KEYED_SLOT_BUFFER_UNIT_MACROS_SVH

// same-cycle implication
`define KSB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed slot buffer check failed");

// next-cycle implication
`define KSB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed slot buffer check failed");

`endif

FILE: hdl/ksb_pkg.sv
package ksb_pkg;

	localparam int SLOT_COUNT   = 16;
	localparam int PAYLOAD_BITS = 64;

	localparam int TX_W   = 16;
	localparam int SRC_W  = 8;
	localparam int KEY_W  = 16;
	localparam int PLD_W  = 64;
	localparam int CFG_W  = 5;

	localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_RD_SRC = 2'd1,
		ACT_RD_TX  = 2'd2
	} action_t;

	localparam logic [1:0] ST_WRITTEN = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_FOUND   = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	typedef struct packed {
		logic [TX_W-1:0]         tx_id;
		logic [SRC_W-1:0]        source_id;
		logic [PAYLOAD_BITS-1:0] payload;
	} rec_t;

	typedef struct packed {
		action_t         action;
		rec_t            rec;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic tok;
		logic take;
		logic pass;
		logic stop;
	} cell_st_t;

endpackage

FILE: hdl/ksb_cell.sv
module ksb_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            start,
	input  logic            tok_in,
	input  logic            active,
	input  ksb_pkg::req_t   req,
	output ksb_pkg::cell_st_t st,
	output ksb_pkg::rec_t   rd_rec
);
	import ksb_pkg::*;

	logic token_q;
	logic taken_q;
	rec_t rec_q;
	logic fit;
	logic take;

	always_comb begin
		case (req.action)
			ACT_WRITE:  fit = !taken_q;
			ACT_RD_SRC: fit = taken_q && ({{(KEY_W-SRC_W){1'b0}}, rec_q.source_id} == req.key);
			ACT_RD_TX:  fit = taken_q && (rec_q.tx_id == req.key);
			default:    fit = 1'b0;
		endcase
	end

	assign take    = token_q && active && fit;
	assign st.tok  = token_q;
	assign st.take = take;
	assign st.pass = token_q && active && !fit;
	assign st.stop = token_q && !active;

	// only a read hands the record out, so the one-hot or in the top works
	assign rd_rec = (take && req.action != ACT_WRITE) ? rec_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
			taken_q <= 1'b0;
		end else begin
			if (start || en) begin
				token_q <= start || tok_in;
			end
			if (en && take) begin
				taken_q <= (req.action == ACT_WRITE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && take && req.action == ACT_WRITE) begin
			rec_q <= req.rec;
		end
	end

endmodule

FILE: hdl/keyed_slot_buffer_unit.sv
// Keyed slot buffer: SLOT_COUNT record slots, each in its own cell with an
// occupancy flag. A write goes to the lowest free slot (dropped when none is
// free), a read by source id or transaction id frees and returns the lowest
// occupied slot whose field matches the key. The search is a token that walks
// the row of cells one slot per cycle starting at slot 0; it visits 1 to
// SLOT_COUNT cells, and the cell that decides ends it and its result is
// registered in the output register. A new item is taken the cycle after
// the result lands in the output register, so the block takes no new item
// before it is through with the last one, and a result left waiting in
// the output register freezes the walk of the next item.
// slots_in_use limits the walk to the lowest slots; zero makes every write
// drop and every read miss. Occupancy clears at reset, no clearing pass.
module keyed_slot_buffer_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [1:0]   s_axis_tuser,  // action
	input  logic [103:0] s_axis_tdata,  // in_tx_id, in_source_id, in_payload, search_key
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [1:0]   m_axis_tuser,  // status
	output logic [87:0]  m_axis_tdata,  // out_tx_id, out_source_id, out_payload
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data       // slots_in_use
);
	import ksb_pkg::*;

	logic [CFG_W-1:0] slots_q;
	logic             busy_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	rec_t             out_rec_q;
	req_t             req_q;

	logic             accept;
	logic             en;
	logic             done;
	logic             hit;
	logic             is_write;
	cell_st_t         st [SLOT_COUNT];
	rec_t             rd_rec [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] tok_vec;
	logic [SLOT_COUNT-1:0] take_vec;
	logic [SLOT_COUNT-1:0] stop_vec;
	rec_t             rd_any;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !busy_q;
	assign cfg_ready     = 1'b1;
	assign en            = !out_valid_q || m_axis_tready;

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		logic tok_in;
		logic active;
		if (g == 0) begin : g_head
			assign tok_in = 1'b0;
		end else begin : g_link
			assign tok_in = st[g-1].pass;
		end
		assign active = (32'(slots_q) > 32'(g));

		ksb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.start  ((g == 0) && accept),
			.tok_in (tok_in),
			.active (active),
			.req    (req_q),
			.st     (st[g]),
			.rd_rec (rd_rec[g])
		);

		assign tok_vec[g]  = st[g].tok;
		assign take_vec[g] = st[g].take;
		assign stop_vec[g] = st[g].stop;
	end

	always_comb begin
		rd_any = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			rd_any = rd_any | rd_rec[i];
		end
	end

	assign hit      = |take_vec;
	assign is_write = (req_q.action == ACT_WRITE);
	assign done     = en && (hit || (|stop_vec) || st[SLOT_COUNT-1].pass);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q     <= SLOTS_RESET;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				slots_q <= cfg_data;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.action            <= action_t'(s_axis_tuser);
			req_q.rec.tx_id         <= s_axis_tdata[15:0];
			req_q.rec.source_id     <= s_axis_tdata[23:16];
			req_q.rec.payload       <= s_axis_tdata[24 +: PAYLOAD_BITS];
			req_q.key               <= s_axis_tdata[103:88];
		end
		if (done) begin
			out_rec_q <= rd_any;
			if (hit) begin
				out_status_q <= is_write ? ST_WRITTEN : ST_FOUND;
			end else begin
				out_status_q <= is_write ? ST_DROPPED : ST_NONE;
			end
		end
	end

	assign m_axis_tvalid        = out_valid_q;
	assign m_axis_tuser         = out_status_q;
	assign m_axis_tdata[15:0]   = out_rec_q.tx_id;
	assign m_axis_tdata[23:16]  = out_rec_q.source_id;
	assign m_axis_tdata[87:24]  = PLD_W'(out_rec_q.payload);

`include "keyed_slot_buffer_unit_macros.svh"

	`KSB_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec))
	`KSB_ASSERT_NOW(a_one_take, 1'b1, $onehot0(take_vec))
	`KSB_ASSERT_NEXT(a_accept_busy, accept, busy_q && tok_vec[0])
	`KSB_ASSERT_NEXT(a_done_out, done, out_valid_q && !busy_q)

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ksb_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [1:0]         status;
		logic [TX_W-1:0]    tx_id;
		logic [SRC_W-1:0]   source_id;
		logic [PLD_W-1:0]   payload;
	} reply_t;

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [1:0]    s_axis_tuser;
	logic [103:0]  s_axis_tdata;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [1:0]    m_axis_tuser;
	logic [87:0]   m_axis_tdata;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [4:0]    cfg_data;

	// mirror of the slot store
	logic [CFG_W-1:0]   slots_used;
	bit                 slot_busy [SLOT_COUNT];
	logic [TX_W-1:0]    slot_tx [SLOT_COUNT];
	logic [SRC_W-1:0]   slot_src [SLOT_COUNT];
	logic [PLD_W-1:0]   slot_pld [SLOT_COUNT];

	reply_t awaited_replies[$];

	int send_idle_pct;
	int rx_idle_pct;
	int rx_hold_left;
	int mismatches;
	int cycles;
	int items_sent;
	int slot_settings;
	int n_written, n_dropped, n_found, n_missed;

	keyed_slot_buffer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycles,
				awaited_replies.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic int active_slots();
		return (slots_used > SLOT_COUNT) ? SLOT_COUNT : int'(slots_used);
	endfunction

	function automatic reply_t apply_to_slots(logic [1:0] act, logic [TX_W-1:0] tx,
			logic [SRC_W-1:0] src, logic [PLD_W-1:0] pld, logic [KEY_W-1:0] key);
		reply_t r;
		int n;
		int i;
		bit hit;
		bit match;
		r = '0;
		r.status = ST_NONE;
		n = active_slots();
		hit = 1'b0;
		case (act)
			ACT_WRITE: begin
				r.status = ST_DROPPED;
				for (i = 0; i < n && !hit; i++) begin
					if (!slot_busy[i]) begin
						slot_busy[i] = 1'b1;
						slot_tx[i] = tx;
						slot_src[i] = src;
						slot_pld[i] = pld;
						r.status = ST_WRITTEN;
						hit = 1'b1;
					end
				end
			end
			ACT_RD_SRC, ACT_RD_TX: begin
				for (i = 0; i < n && !hit; i++) begin
					match = (act == ACT_RD_SRC) ? ({8'd0, slot_src[i]} == key)
						: (slot_tx[i] == key);
					if (slot_busy[i] && match) begin
						slot_busy[i] = 1'b0;
						r.tx_id = slot_tx[i];
						r.source_id = slot_src[i];
						r.payload = slot_pld[i];
						r.status = ST_FOUND;
						hit = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// key for a read: mostly one that is stored, else random and sometimes too wide
	function automatic logic [KEY_W-1:0] pick_key(bit by_src);
		int idx[$];
		int i;
		int k;
		for (i = 0; i < active_slots(); i++)
			if (slot_busy[i])
				idx.push_back(i);
		if (idx.size() > 0 && $urandom_range(0, 99) < 75) begin
			k = idx[$urandom_range(0, idx.size() - 1)];
			return by_src ? {8'd0, slot_src[k]} : slot_tx[k];
		end
		if (by_src && $urandom_range(0, 99) < 80)
			return {8'd0, 8'($urandom)};
		return 16'($urandom);
	endfunction

	task automatic send_item(logic [1:0] act, logic [TX_W-1:0] tx, logic [SRC_W-1:0] src,
			logic [PLD_W-1:0] pld, logic [KEY_W-1:0] key);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {key, pld, src, tx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		awaited_replies.push_back(apply_to_slots(act, tx, src, pld, key));
		items_sent++;
	endtask

	task automatic set_slot_count(logic [CFG_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		slots_used = v;
		slot_settings++;
	endtask

	task automatic send_random_item(int write_pct);
		logic [1:0] act;
		logic [TX_W-1:0] tx;
		logic [SRC_W-1:0] src;
		logic [KEY_W-1:0] key;
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			act = ACT_UNUSED;
		else if ($urandom_range(0, 99) < write_pct)
			act = ACT_WRITE;
		else
			act = ($urandom_range(0, 1) == 0) ? ACT_RD_SRC : ACT_RD_TX;
		tx = ($urandom_range(0, 99) < 40) ? TX_W'($urandom_range(0, 7)) : TX_W'($urandom);
		src = ($urandom_range(0, 99) < 50) ? SRC_W'($urandom_range(0, 3)) : SRC_W'($urandom);
		if (act == ACT_RD_SRC)
			key = pick_key(1'b1);
		else if (act == ACT_RD_TX)
			key = pick_key(1'b0);
		else
			key = KEY_W'($urandom);
		send_item(act, tx, src, {$urandom, $urandom}, key);
	endtask

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tuser;
			got.tx_id = m_axis_tdata[15:0];
			got.source_id = m_axis_tdata[23:16];
			got.payload = m_axis_tdata[87:24];
			if (awaited_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply status %0d tx %h src %h pld %h",
						got.status, got.tx_id, got.source_id, got.payload);
			end else begin
				want = awaited_replies.pop_front();
				case (want.status)
					ST_WRITTEN: n_written++;
					ST_DROPPED: n_dropped++;
					ST_FOUND:   n_found++;
					default:    n_missed++;
				endcase
				if (got.status !== want.status || got.tx_id !== want.tx_id
						|| got.source_id !== want.source_id || got.payload !== want.payload) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply mismatch: exp st %0d tx %h src %h pld %h, got st %0d tx %h src %h pld %h",
							want.status, want.tx_id, want.source_id, want.payload,
							got.status, got.tx_id, got.source_id, got.payload);
				end
			end
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic test_priority_and_keys();
		set_slot_count(CFG_W'(3));
		send_item(ACT_WRITE, 16'hFFFF, 8'hFF, {64{1'b1}}, 16'hFFFF);
		send_item(ACT_WRITE, 16'h0000, 8'h00, 64'd0, 16'h0000);
		send_item(ACT_WRITE, 16'h1234, 8'hFF, 64'hA5A5_5A5A_0F0F_F0F0, 16'h5A5A);
		// full, so dropped
		send_item(ACT_WRITE, 16'h5555, 8'h01, 64'h1, 16'h0001);
		// wide source key must not match on its low byte
		send_item(ACT_RD_SRC, 16'h0, 8'h0, 64'd0, 16'h01FF);
		send_item(ACT_RD_SRC, 16'h0, 8'h0, 64'd0, 16'h00FF);
		send_item(ACT_RD_SRC, 16'h0, 8'h0, 64'd0, 16'h00FF);
		send_item(ACT_WRITE, 16'h8000, 8'h80, 64'h8000_0000_0000_0000, 16'hAAAA);
		send_item(ACT_RD_TX, 16'hFFFF, 8'hFF, {64{1'b1}}, 16'h0000);
		send_item(ACT_RD_TX, 16'hFFFF, 8'hFF, {64{1'b1}}, 16'h0000);
		send_item(ACT_UNUSED, 16'hFFFF, 8'hFF, {64{1'b1}}, 16'hFFFF);
		send_item(ACT_RD_TX, 16'h0, 8'h0, 64'd0, 16'h8000);
		send_item(ACT_RD_SRC, 16'h0, 8'h0, 64'd0, 16'h0000);
	endtask

	task automatic test_slot_limits();
		set_slot_count(CFG_W'(0));
		send_item(ACT_WRITE, 16'h0042, 8'h42, 64'h42, 16'h0);
		send_item(ACT_RD_SRC, 16'h0, 8'h0, 64'd0, 16'h0000);
		set_slot_count(CFG_W'(1));
		send_item(ACT_WRITE, 16'h0101, 8'h11, 64'h0123_4567_89AB_CDEF, 16'h0);
		send_item(ACT_WRITE, 16'h0202, 8'h22, 64'hFEDC_BA98_7654_3210, 16'h0);
		send_item(ACT_RD_TX, 16'h0, 8'h0, 64'd0, 16'h0101);
		set_slot_count(CFG_W'(31));
		send_item(ACT_WRITE, 16'h7FFF, 8'h7F, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0);
		send_item(ACT_RD_SRC, 16'h0, 8'h0, 64'd0, 16'h007F);
	endtask

	task automatic test_random_traffic(int send_pct, int rx_pct, int n_items);
		int i;
		int pick;
		send_idle_pct = send_pct;
		rx_idle_pct = rx_pct;
		for (i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				pick = $urandom_range(0, 9);
				case (pick)
					0: set_slot_count(CFG_W'(1));
					1: set_slot_count(CFG_W'(2));
					2, 3: set_slot_count(CFG_W'(16));
					4: set_slot_count(CFG_W'(31));
					5: set_slot_count(CFG_W'($urandom_range(17, 31)));
					6: set_slot_count(CFG_W'(($urandom_range(0, 19) == 0) ? 0 : 4));
					default: set_slot_count(CFG_W'($urandom_range(1, 16)));
				endcase
			end
			// alternate fill-heavy and drain-heavy stretches
			send_random_item(((i / 25) % 2 == 0) ? 70 : 30);
		end
	endtask

	task automatic test_backpressure();
		int i;
		set_slot_count(CFG_W'(16));
		send_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = 300;
		for (i = 0; i < 40; i++)
			send_random_item(60);
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= ACT_WRITE;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		slots_used = SLOTS_RESET;
		foreach (slot_busy[i]) begin
			slot_busy[i] = 1'b0;
			slot_tx[i] = '0;
			slot_src[i] = '0;
			slot_pld[i] = '0;
		end
		send_idle_pct = 12;
		rx_idle_pct = 71;
		rx_hold_left = 0;
		mismatches = 0;
		cycles = 0;
		items_sent = 0;
		slot_settings = 0;
		n_written = 0;
		n_dropped = 0;
		n_found = 0;
		n_missed = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_priority_and_keys();
		test_slot_limits();
		test_random_traffic(12, 71, 400);
		test_random_traffic(71, 12, 400);
		test_backpressure();
		test_random_traffic(0, 0, 400);

		s_axis_tvalid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("run covered %0d items across %0d slot-count settings",
			items_sent, slot_settings);
		$display("outcomes: %0d stored, %0d dropped full, %0d read hits, %0d misses",
			n_written, n_dropped, n_found, n_missed);
		if (mismatches == 0 && awaited_replies.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
